/* hw/rtl/zma_pkg.sv */
// Package for the Zernike moment accumulator: types, constants and the coefficient table.
`default_nettype none
package zma_pkg;
   localparam int MAX_ORDER_DEF       = 12;
   localparam int COORD_FRAC_BITS_DEF = 15;
   localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;

   typedef enum logic [3:0] {
      ST_IDLE, ST_R2, ST_WMUL, ST_WSUM, ST_HORN, ST_HSUM,
      ST_PR, ST_PI, ST_CR, ST_CI, ST_ACC, ST_SR, ST_SI, ST_OUT
   } state_type;

   // Multiplier operand selection.
   typedef enum logic [3:0] {
      OP_WR_X, OP_WI_Y, OP_WI_X, OP_WR_Y, OP_RAD_R2,
      OP_RAD_WR, OP_RAD_WI, OP_P_TR, OP_P_TI, OP_ACCR_K, OP_ACCI_K
   } mop_type;

   typedef struct packed {
      logic     load;     // latch pixel and reset w
      logic     r2_go;    // form r2
      logic     mul_go;   // start one product
      mop_type  mop;
      logic [1:0] slot;   // product slot to write
      logic     w_upd;    // combine four products into w
      logic     h_upd;    // rad = prod + coeff
      logic     acc_upd;  // add contributions
      logic     acc_clr;
      logic     out_ld;   // load output word
      logic     out_bad;
      logic [3:0] m_idx;
   } cmd_type;

   // Binomial coefficients C(a, b) for a, b below 16; zero where b > a.
   typedef logic [15:0][15:0][15:0] pascal_type;

   function automatic pascal_type make_pascal();
      pascal_type t;
      t = '0;
      for (int r = 0; r < 16; r++) begin
         t[r][0] = 16'd1;
         for (int c = 1; c <= r; c++) t[r][c] = t[r-1][c-1] + t[r-1][c];
      end
      return t;
   endfunction

   localparam pascal_type PASCAL = make_pascal();

   // Coefficient magnitude c_m for (n, l, m) as integer, the product of two constant-table entries.
   function automatic logic [47:0] coeff_mag(input logic [3:0] n, input logic [3:0] l,
                                              input logic [3:0] m);
      logic [3:0] k;
      logic [15:0] ba, bb;
      k = 4'((n - l) >> 1);
      ba = PASCAL[4'(n - m)][m];
      bb = PASCAL[4'(n - {m[2:0], 1'b0})][4'(k - m)];
      return 48'(32'(ba) * 32'(bb));
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/zma_ctrl.sv */
// Sequencer for the per-pixel product chain and the final scaling.
`default_nettype none
module zma_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_last_pixel,
   input  wire logic              ok,
   input  wire logic [3:0]        l_cfg,
   input  wire logic [3:0]        k_cfg,
   input  wire logic              out_busy,
   input  wire logic              mul_done,
   output zma_pkg::cmd_type       cmd
);
   zma_pkg::state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] sub_ff, sub_in;
   logic last_ff, last_in;
   logic issued_ff, issued_in;
   logic mul_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zma_pkg::ST_IDLE;
         cnt_ff <= '0;
         sub_ff <= '0;
         last_ff <= 1'b0;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sub_ff <= sub_in;
         last_ff <= last_in;
         issued_ff <= issued_in;
      end
   end

   // A product state starts the multiplier once, then waits for its result.
   assign mul_fire = issued_ff && mul_done;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sub_in = sub_ff;
      last_in = last_ff;
      issued_in = issued_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.mop = zma_pkg::OP_WR_X;
      cmd.m_idx = cnt_ff;
      case (state_ff)
         zma_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               last_in = req_last_pixel;
               cmd.load = 1'b1;
               cnt_in = '0;
               sub_in = '0;
               state_in = ok ? zma_pkg::ST_R2 : (req_last_pixel ? zma_pkg::ST_OUT
                                                               : zma_pkg::ST_IDLE);
            end
         end
         zma_pkg::ST_R2: begin
            cmd.r2_go = 1'b1;
            state_in = (l_cfg != 0) ? zma_pkg::ST_WMUL
                     : ((k_cfg != 0) ? zma_pkg::ST_HORN : zma_pkg::ST_PR);
            cnt_in = (l_cfg != 0) ? 4'd0 : 4'd1;
         end
         zma_pkg::ST_WMUL: begin
            cmd.mul_go = !issued_ff;
            issued_in = !mul_fire;
            cmd.slot = sub_ff;
            case (sub_ff)
               2'd0: cmd.mop = zma_pkg::OP_WR_X;
               2'd1: cmd.mop = zma_pkg::OP_WI_Y;
               2'd2: cmd.mop = zma_pkg::OP_WI_X;
               default: cmd.mop = zma_pkg::OP_WR_Y;
            endcase
            if (mul_fire) begin
               sub_in = sub_ff + 2'd1;
               if (sub_ff == 2'd3) state_in = zma_pkg::ST_WSUM;
            end
         end
         zma_pkg::ST_WSUM: begin
            cmd.w_upd = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff + 4'd1 == l_cfg) begin
               cnt_in = 4'd1;
               state_in = (k_cfg != 0) ? zma_pkg::ST_HORN : zma_pkg::ST_PR;
            end else state_in = zma_pkg::ST_WMUL;
         end
         zma_pkg::ST_HORN: begin
            cmd.mul_go = !issued_ff;
            issued_in = !mul_fire;
            cmd.mop = zma_pkg::OP_RAD_R2;
            cmd.slot = 2'd0;
            if (mul_fire) state_in = zma_pkg::ST_HSUM;
         end
         zma_pkg::ST_HSUM: begin
            cmd.h_upd = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            state_in = (cnt_ff == k_cfg) ? zma_pkg::ST_PR : zma_pkg::ST_HORN;
         end
         zma_pkg::ST_PR: begin
            cmd.mul_go = !issued_ff; issued_in = !mul_fire;
            cmd.mop = zma_pkg::OP_RAD_WR; cmd.slot = 2'd0;
            if (mul_fire) state_in = zma_pkg::ST_PI;
         end
         zma_pkg::ST_PI: begin
            cmd.mul_go = !issued_ff; issued_in = !mul_fire;
            cmd.mop = zma_pkg::OP_RAD_WI; cmd.slot = 2'd1;
            if (mul_fire) state_in = zma_pkg::ST_CR;
         end
         zma_pkg::ST_CR: begin
            cmd.mul_go = !issued_ff; issued_in = !mul_fire;
            cmd.mop = zma_pkg::OP_P_TR; cmd.slot = 2'd2;
            if (mul_fire) state_in = zma_pkg::ST_CI;
         end
         zma_pkg::ST_CI: begin
            cmd.mul_go = !issued_ff; issued_in = !mul_fire;
            cmd.mop = zma_pkg::OP_P_TI; cmd.slot = 2'd3;
            if (mul_fire) state_in = zma_pkg::ST_ACC;
         end
         zma_pkg::ST_ACC: begin
            cmd.acc_upd = 1'b1;
            state_in = last_ff ? zma_pkg::ST_SR : zma_pkg::ST_IDLE;
         end
         zma_pkg::ST_SR: begin
            cmd.mul_go = !issued_ff; issued_in = !mul_fire;
            cmd.mop = zma_pkg::OP_ACCR_K; cmd.slot = 2'd0;
            if (mul_fire) state_in = zma_pkg::ST_SI;
         end
         zma_pkg::ST_SI: begin
            cmd.mul_go = !issued_ff; issued_in = !mul_fire;
            cmd.mop = zma_pkg::OP_ACCI_K; cmd.slot = 2'd1;
            if (mul_fire) state_in = zma_pkg::ST_OUT;
         end
         zma_pkg::ST_OUT: begin
            if (!out_busy) begin
               cmd.out_ld = 1'b1;
               cmd.out_bad = !ok;
               cmd.acc_clr = 1'b1;
               state_in = zma_pkg::ST_IDLE;
            end
         end
         default: state_in = zma_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* hw/rtl/zma_datapath.sv */
// Datapath: operand registers, one shared multi-cycle multiplier, accumulators, output register.
`default_nettype none
module zma_datapath #(
   parameter int COORD_FRAC_BITS = zma_pkg::COORD_FRAC_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire zma_pkg::cmd_type    cmd,
   input  wire logic [3:0]          n_cfg,
   input  wire logic [3:0]          l_cfg,
   input  wire logic signed [15:0]  req_x_coord,
   input  wire logic signed [15:0]  req_y_coord,
   input  wire logic [15:0]         req_pixel_value,
   input  wire logic                rsp_ready,
   output logic                     mul_done,
   output logic                     rsp_valid,
   output logic signed [63:0]       rsp_moment_real,
   output logic signed [63:0]       rsp_moment_imag,
   output logic                     rsp_bad_setting
);
   localparam int F = COORD_FRAC_BITS;
   localparam logic signed [63:0] SMAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SMIN = {1'b1, {63{1'b0}}};

   logic signed [15:0] x_ff, y_ff;
   logic [15:0] p_ff;
   logic signed [63:0] r2_ff, wr_ff, wi_ff, rad_ff, acc_r_ff, acc_i_ff;
   logic signed [63:0] pr_ff [4];
   logic valid_ff;
   logic signed [63:0] mr_ff, mi_ff;
   logic bad_ff;

   // Coefficient for the current Horner step (signed, Q.F).
   logic [47:0] cmag;
   logic signed [63:0] coef;
   assign cmag = zma_pkg::coeff_mag(n_cfg, l_cfg, cmd.m_idx);
   always_comb begin
      coef = 64'(cmag) <<< F;
      if (cmd.m_idx[0]) coef = -coef;
   end

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(SMAX)) return SMAX;
      if (s < 65'(SMIN)) return SMIN;
      return s[63:0];
   endfunction

   // Scale factor (n+1) * round(2^32/pi) for the final step.
   logic [4:0] n1;
   logic [36:0] kscale;
   assign n1 = {1'b0, n_cfg} + 5'd1;
   assign kscale = 37'(n1) * 37'(zma_pkg::INV_PI_Q32);

   // Operand selection for the shared multiplier.
   logic signed [63:0] opa, opb;
   logic [5:0] shamt;
   always_comb begin
      opa = '0; opb = '0; shamt = 6'(F);
      case (cmd.mop)
         zma_pkg::OP_WR_X:   begin opa = wr_ff;  opb = 64'(x_ff); end
         zma_pkg::OP_WI_Y:   begin opa = wi_ff;  opb = 64'(y_ff); end
         zma_pkg::OP_WI_X:   begin opa = wi_ff;  opb = 64'(x_ff); end
         zma_pkg::OP_WR_Y:   begin opa = wr_ff;  opb = 64'(y_ff); end
         zma_pkg::OP_RAD_R2: begin opa = rad_ff; opb = r2_ff; end
         zma_pkg::OP_RAD_WR: begin opa = rad_ff; opb = wr_ff; end
         zma_pkg::OP_RAD_WI: begin opa = rad_ff; opb = wi_ff; end
         zma_pkg::OP_P_TR:   begin opa = 64'({p_ff, {F{1'b0}}}); opb = pr_ff[0]; end
         zma_pkg::OP_P_TI:   begin opa = 64'({p_ff, {F{1'b0}}}); opb = pr_ff[1]; end
         zma_pkg::OP_ACCR_K: begin
            opa = acc_r_ff; opb = 64'(kscale);
            shamt = 6'd32;
         end
         zma_pkg::OP_ACCI_K: begin
            opa = acc_i_ff; opb = 64'(kscale);
            shamt = 6'd32;
         end
         default: ;
      endcase
   end

   // The magnitudes are multiplied 64 x 16 bits per cycle, one 16-bit slice of the second
   // operand at a time; the sum is then rounded, shifted and saturated into the slot.
   logic [63:0] ma_ff, mb_ff;
   logic neg_ff;
   logic [5:0] sh_ff;
   logic [1:0] slot_ff;
   logic [127:0] macc_ff;
   logic [2:0] mcnt_ff;
   logic busy_ff;
   logic [79:0] part;
   logic [127:0] rnd, q;
   logic signed [63:0] mres;

   assign part = 80'(ma_ff) * 80'(mb_ff[15:0]);
   assign mul_done = busy_ff && (mcnt_ff == 3'd4);

   always_comb begin
      rnd = macc_ff + (128'd1 << (sh_ff - 6'd1));
      q = rnd >> sh_ff;
      if (q[127:63] != '0) mres = neg_ff ? SMIN : SMAX;
      else mres = neg_ff ? -$signed(q[63:0]) : $signed(q[63:0]);
   end

   logic signed [31:0] xs, ys;
   logic [31:0] sq;
   assign xs = 32'(x_ff);
   assign ys = 32'(y_ff);
   assign sq = 32'(xs * xs) + 32'(ys * ys);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_x_coord;
         y_ff <= req_y_coord;
         p_ff <= req_pixel_value;
         wr_ff <= 64'sd1 <<< F;
         wi_ff <= '0;
      end
      if (cmd.r2_go) begin
         r2_ff <= 64'((33'(sq) + (33'd1 << (F - 1))) >> F);
         rad_ff <= 64'(zma_pkg::coeff_mag(n_cfg, l_cfg, 4'd0)) <<< F;
      end
      if (cmd.mul_go) begin
         ma_ff <= opa[63] ? 64'(-opa) : 64'(opa);
         mb_ff <= opb[63] ? 64'(-opb) : 64'(opb);
         neg_ff <= opa[63] ^ opb[63];
         sh_ff <= shamt;
         slot_ff <= cmd.slot;
         macc_ff <= '0;
         mcnt_ff <= '0;
      end else if (busy_ff && mcnt_ff != 3'd4) begin
         macc_ff <= macc_ff + (128'(part) << {mcnt_ff[1:0], 4'd0});
         mb_ff <= mb_ff >> 16;
         mcnt_ff <= mcnt_ff + 3'd1;
      end
      if (mul_done) pr_ff[slot_ff] <= mres;
      if (cmd.w_upd) begin
         wr_ff <= sat_add(pr_ff[0], pr_ff[1]);
         wi_ff <= (pr_ff[3] == SMIN) ? (pr_ff[2][63] ? sat_add(sat_add(pr_ff[2], SMAX), 64'sd1)
                                                     : SMAX)
                  : sat_add(pr_ff[2], -pr_ff[3]);
      end
      if (cmd.h_upd) rad_ff <= sat_add(pr_ff[0], coef);
      if (cmd.out_ld) begin
         mr_ff <= cmd.out_bad ? 64'sd0 : pr_ff[0];
         mi_ff <= cmd.out_bad ? 64'sd0 : pr_ff[1];
         bad_ff <= cmd.out_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_r_ff <= '0;
         acc_i_ff <= '0;
         valid_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         if (cmd.acc_upd) begin
            acc_r_ff <= sat_add(acc_r_ff, pr_ff[2]);
            acc_i_ff <= sat_add(acc_i_ff, pr_ff[3]);
         end else if (cmd.acc_clr) begin
            acc_r_ff <= '0;
            acc_i_ff <= '0;
         end
         if (cmd.out_ld) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
         if (cmd.mul_go) busy_ff <= 1'b1;
         else if (mul_done) busy_ff <= 1'b0;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_moment_real = mr_ff;
   assign rsp_moment_imag = mi_ff;
   assign rsp_bad_setting = bad_ff;
endmodule
`default_nettype wire

/* hw/rtl/zernike_moment_accumulator.sv */
// Top level of the Zernike moment accumulator: register file, controller and datapath.
//
//  Channel   Ports                      Direction  Content
//  req_      valid/ready + 4 fields     in         one pixel word
//  rsp_      valid/ready + 3 fields     out        one moment word per pixel set
//  csr_      valid/ready + index/data   in         order_n, repetition_l
//
// Every product goes through one shared multiplier, so the time a pixel takes grows with
// l and with k = (n-l)/2; a pixel is accepted only while the controller is idle.
// The last pixel adds the two scaling products and the output step.
// With an invalid setting a pixel is just accepted; the last also takes the output step.
// Reset is synchronous and clears the accumulators, settings and control state.
// The moment word waits in its own register, so the next set carries on meanwhile; only
// the output step of the next set stalls until rsp_ready has taken the earlier word.
`default_nettype none
module zernike_moment_accumulator #(
   parameter int MAX_ORDER       = zma_pkg::MAX_ORDER_DEF,
   parameter int COORD_FRAC_BITS = zma_pkg::COORD_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_x_coord,
   input  wire logic signed [15:0] req_y_coord,
   input  wire logic [15:0]        req_pixel_value,
   input  wire logic               req_last_pixel,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [63:0]      rsp_moment_real,
   output logic signed [63:0]      rsp_moment_imag,
   output logic                    rsp_bad_setting,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [3:0]         csr_data
);
   logic [3:0] n_ff, l_ff;
   logic ok;
   logic [3:0] k;
   logic out_busy;
   logic mul_done;
   zma_pkg::cmd_type cmd;

   // Settings are taken whenever offered.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
         l_ff <= '0;
      end else if (csr_valid) begin
         if (!csr_index) n_ff <= csr_data;
         else l_ff <= csr_data;
      end
   end

   // The setting is usable when l <= n, n-l is even and n is within range.
   assign ok = (l_ff <= n_ff) && !(n_ff[0] ^ l_ff[0]) && (32'(n_ff) <= MAX_ORDER);
   assign k = 4'((n_ff - l_ff) >> 1);

   // The output register is free when empty or being read in this cycle.
   assign out_busy = rsp_valid && !rsp_ready;

   zma_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_last_pixel,
      .ok, .l_cfg(l_ff), .k_cfg(k), .out_busy, .mul_done, .cmd
   );

   zma_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .n_cfg(n_ff), .l_cfg(l_ff),
      .req_x_coord, .req_y_coord, .req_pixel_value,
      .rsp_ready, .mul_done, .rsp_valid, .rsp_moment_real, .rsp_moment_imag,
      .rsp_bad_setting
   );
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the Zernike moment accumulator.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   // Register indexes of the configuration port.
   localparam logic REG_ORDER_N      = 1'b0;
   localparam logic REG_REPETITION_L = 1'b1;

   // The settle wait outlasts the longest pixel plus the scaling and output steps, so it
   // comfortably covers any work still in flight.
   localparam int SETTLE_CYCLES = 1200;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int F = zma_pkg::COORD_FRAC_BITS_DEF;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        pix;
      logic               last;
   } pixel_word_type;

   typedef struct {
      logic signed [63:0] re;
      logic signed [63:0] im;
      logic               bad;
   } moment_word_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_x_coord;
   logic signed [15:0] req_y_coord;
   logic [15:0]        req_pixel_value;
   logic               req_last_pixel;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [63:0] rsp_moment_real;
   logic signed [63:0] rsp_moment_imag;
   logic               rsp_bad_setting;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [3:0]         csr_data;

   zernike_moment_accumulator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .req_pixel_value(req_pixel_value), .req_last_pixel(req_last_pixel),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_moment_real(rsp_moment_real), .rsp_moment_imag(rsp_moment_imag),
      .rsp_bad_setting(rsp_bad_setting),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Pixel words waiting to be driven, and moment words the block still owes us.
   pixel_word_type  pending_pixels[$];
   moment_word_type owed_moments[$];

   // Our own copy of the settings and the complex accumulator.
   logic [3:0]         shadow_n;
   logic [3:0]         shadow_l;
   logic signed [63:0] sum_re;
   logic signed [63:0] sum_im;

   int errors;
   int pixels_taken;
   int moments_seen;
   int bad_moments_seen;
   int csr_writes;
   int cycle_count;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A long stretch in the middle of the run has no idling on either side.
   function automatic logic take_a_break();
      if (cycle_count > 40000 && cycle_count < 70000) return 1'b0;
      return $urandom_range(99) < 8;
   endfunction

   function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
   endfunction

   // round(|a|*|b| / 2^s), half away from zero, sign applied, saturated.
   function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int s);
      logic [63:0]  ma, mb;
      logic [127:0] prod;
      logic         neg;
      ma = a[63] ? 64'(-a) : 64'(a);
      mb = b[63] ? 64'(-b) : 64'(b);
      neg = a[63] != b[63];
      prod = (128'(ma) * 128'(mb) + (128'd1 << (s - 1))) >> s;
      if (prod >= (128'd1 << 63))
         return neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
   endfunction

   function automatic logic [63:0] choose(input int a, input int b);
      logic [63:0] r;
      r = 64'd1;
      for (int i = 0; i < b; i++) r = r * 64'(a - i) / 64'(i + 1);
      return r;
   endfunction

   // Signed radial coefficient of term m, in Q.F.
   function automatic logic signed [63:0] radial_coeff(input int n, input int k, input int m);
      logic signed [63:0] v;
      v = $signed((choose(n - m, m) * choose(n - 2 * m, k - m)) << F);
      return (m % 2 == 1) ? -v : v;
   endfunction

   // Adds one pixel into the accumulator copy and, on the last pixel, owes a moment word.
   task automatic accumulate_pixel(input pixel_word_type w);
      logic ok;
      logic signed [63:0] x, y, p, r2, wr, wi, nr, ni, rad;
      logic [63:0] kscale;
      moment_word_type m;
      int k;
      ok = shadow_l <= shadow_n && ((shadow_n - shadow_l) % 2 == 0)
           && shadow_n <= zma_pkg::MAX_ORDER_DEF;
      if (ok) begin
         x = 64'(w.x);
         y = 64'(w.y);
         p = $signed(64'(w.pix) << F);
         r2 = (x * x + y * y + (64'sd1 <<< (F - 1))) >>> F;
         wr = 64'sd1 <<< F;
         wi = 0;
         k = (shadow_n - shadow_l) / 2;
         // Conjugate angular factor (x - iy)^l, one complex product per step.
         for (int i = 0; i < shadow_l; i++) begin
            nr = sat_sum(scaled_product(wr, x, F), scaled_product(wi, y, F));
            ni = sat_sum(scaled_product(wi, x, F), -scaled_product(wr, y, F));
            if (scaled_product(wr, y, F) == 64'sh8000_0000_0000_0000)
               ni = (scaled_product(wi, x, F) >= 0) ? 64'sh7FFF_FFFF_FFFF_FFFF
                    : sat_sum(sat_sum(scaled_product(wi, x, F), 64'sh7FFF_FFFF_FFFF_FFFF), 1);
            wr = nr;
            wi = ni;
         end
         // Radial polynomial in r^2 by Horner's rule.
         rad = radial_coeff(shadow_n, k, 0);
         for (int i = 1; i <= k; i++)
            rad = sat_sum(scaled_product(rad, r2, F), radial_coeff(shadow_n, k, i));
         sum_re = sat_sum(sum_re, scaled_product(p, scaled_product(rad, wr, F), F));
         sum_im = sat_sum(sum_im, scaled_product(p, scaled_product(rad, wi, F), F));
      end
      if (w.last) begin
         if (ok) begin
            kscale = 64'(shadow_n + 1) * 64'(zma_pkg::INV_PI_Q32);
            m.re = scaled_product(sum_re, $signed(kscale), 32);
            m.im = scaled_product(sum_im, $signed(kscale), 32);
            m.bad = 1'b0;
         end else begin
            m.re = 0;
            m.im = 0;
            m.bad = 1'b1;
         end
         owed_moments.push_back(m);
         sum_re = 0;
         sum_im = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic signed [63:0] want,
                                  input logic signed [63:0] got);
      $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
               what, cycle_count, want, got);
      errors++;
   endtask

   // Driver: presents pending pixel words, holding each one until it is taken.
   always @(posedge clock) begin : pixel_driver
      pixel_word_type w;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            w.x = req_x_coord;
            w.y = req_y_coord;
            w.pix = req_pixel_value;
            w.last = req_last_pixel;
            accumulate_pixel(w);
            pixels_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() > 0 && !take_a_break()) begin
               w = pending_pixels.pop_front();
               req_x_coord <= w.x;
               req_y_coord <= w.y;
               req_pixel_value <= w.pix;
               req_last_pixel <= w.last;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each moment word against the oldest one owed.
   always @(posedge clock) begin : moment_monitor
      moment_word_type m;
      rsp_ready <= reset ? 1'b0 : !take_a_break();
      if (!reset && rsp_valid && rsp_ready) begin
         moments_seen++;
         if (rsp_bad_setting) bad_moments_seen++;
         if (owed_moments.size() == 0) begin
            $display("unexpected moment word at cycle %0d", cycle_count);
            errors++;
         end else begin
            m = owed_moments.pop_front();
            if (rsp_moment_real !== m.re) report_mismatch("moment_real", m.re, rsp_moment_real);
            if (rsp_moment_imag !== m.im) report_mismatch("moment_imag", m.im, rsp_moment_imag);
            if (rsp_bad_setting !== m.bad)
               report_mismatch("bad_setting", 64'(m.bad), 64'(rsp_bad_setting));
         end
      end
   end

   // Watchdog: any handshake counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_setting(input logic idx, input logic [3:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      if (idx == REG_ORDER_N) shadow_n = value;
      else shadow_l = value;
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   // Waits until the block has drained, then lets any unfinished pixel complete.
   task automatic wait_for_idle();
      while (pending_pixels.size() > 0 || req_valid || owed_moments.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic new_setting(input logic [3:0] n, input logic [3:0] l);
      wait_for_idle();
      if ($urandom_range(1)) begin
         write_setting(REG_ORDER_N, n);
         write_setting(REG_REPETITION_L, l);
      end else begin
         write_setting(REG_REPETITION_L, l);
         write_setting(REG_ORDER_N, n);
      end
   endtask

   task automatic queue_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic [15:0] pix, input logic last);
      pixel_word_type w;
      w.x = x;
      w.y = y;
      w.pix = pix;
      w.last = last;
      pending_pixels.push_back(w);
   endtask

   // Mostly points inside the unit disk; sometimes the full coordinate range.
   function automatic logic signed [15:0] random_coord();
      if ($urandom_range(9) < 2) return 16'($urandom);
      return 16'($signed($urandom_range(46340)) - 23170);
   endfunction

   initial begin : stimulus
      int set_len;
      int budget;
      logic [3:0] n, l;
      reset = 1'b1;
      req_valid = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      req_pixel_value = '0;
      req_last_pixel = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_ORDER_N;
      csr_data = '0;
      shadow_n = '0;
      shadow_l = '0;
      sum_re = 0;
      sum_im = 0;
      errors = 0;
      pixels_taken = 0;
      moments_seen = 0;
      bad_moments_seen = 0;
      csr_writes = 0;
      cycle_count = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Reset setting first: n = l = 0 with coordinate extremes.
      queue_pixel(-16'sd32768, -16'sd32768, 16'hFFFF, 1'b0);
      queue_pixel(16'sd32767, 16'sd32767, 16'h0000, 1'b1);
      queue_pixel(16'sd0, 16'sd0, 16'h0001, 1'b1);
      // Highest order and repetition, with points outside the disk to force saturation.
      new_setting(4'd12, 4'd12);
      queue_pixel(-16'sd32768, 16'sd32767, 16'hFFFF, 1'b0);
      queue_pixel(16'sd32767, -16'sd32768, 16'hFFFF, 1'b0);
      queue_pixel(16'sd23170, 16'sd0, 16'h8000, 1'b1);
      // Purely radial moment of the highest order.
      new_setting(4'd12, 4'd0);
      queue_pixel(16'sd16384, -16'sd16384, 16'hFFFF, 1'b0);
      queue_pixel(-16'sd32768, -16'sd32768, 16'hFFFF, 1'b1);
      queue_pixel(16'sd1, 16'sd1, 16'h0001, 1'b1);
      // Repetition above the order.
      new_setting(4'd2, 4'd5);
      queue_pixel(16'sd1000, 16'sd2000, 16'h1234, 1'b0);
      queue_pixel(16'sd1000, 16'sd2000, 16'h1234, 1'b1);
      // Odd difference between order and repetition.
      new_setting(4'd5, 4'd2);
      queue_pixel(-16'sd5000, 16'sd7000, 16'hFFFF, 1'b1);
      // Order beyond MAX_ORDER, with a valid-looking parity.
      new_setting(4'd15, 4'd15);
      queue_pixel(16'sd300, 16'sd300, 16'h00FF, 1'b1);
      new_setting(4'd15, 4'd1);
      queue_pixel(16'sd300, -16'sd300, 16'hFF00, 1'b1);
      // A set that spans a setting change keeps what it has accumulated.
      new_setting(4'd3, 4'd1);
      queue_pixel(16'sd12000, -16'sd9000, 16'h4000, 1'b0);
      new_setting(4'd6, 4'd2);
      queue_pixel(-16'sd8000, 16'sd3000, 16'h7FFF, 1'b1);

      // Random part: sets of random length under a random or extreme setting.
      budget = 1950;
      while (budget > 0) begin
         case ($urandom_range(5))
            0: begin n = 4'd12; l = 4'($urandom_range(6) * 2); end
            1: begin n = 4'($urandom); l = 4'($urandom); end
            default: begin
               n = 4'($urandom_range(12));
               l = 4'($urandom_range(n));
               if ((n - l) % 2 == 1) l = l + 4'd1;
               if (l > n) l = n;
            end
         endcase
         new_setting(n, l);
         for (int phase_items = 0; phase_items < 90 && budget > 0; ) begin
            set_len = ($urandom_range(4) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
            for (int i = 0; i < set_len; i++) begin
               // The odd set is left open so that it straddles the next setting.
               queue_pixel(random_coord(), random_coord(),
                           ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom),
                           i == set_len - 1 && $urandom_range(19) != 0);
               phase_items++;
               budget--;
            end
         end
      end
      queue_pixel(16'sd100, -16'sd100, 16'h0100, 1'b1);
      wait_for_idle();

      $display("covered %0d pixel words, %0d moment words (%0d flagged invalid), %0d setting writes",
               pixels_taken, moments_seen, bad_moments_seen, csr_writes);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", errors);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
